@@ sv/mst_pkg.sv @@
package mst_pkg;

  localparam int MAX_SLOTS_DEF   = 8;
  localparam int TICK_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int ACTIVE_W        = 4;
  localparam int REQ_W           = 2;
  localparam int SLOT_IDX_W      = 3;
  localparam int FLAG_W          = 8;

  localparam logic [CFG_DATA_W-1:0] TICK_PERIOD_RST = 16'hFFFF;

  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ARM    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DISARM = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_PERIOD,
    REG_ACTIVE_SLOTS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_ARM,
    OP_DISARM,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    op_t                   op;
    logic [SLOT_IDX_W-1:0] slot;
  } item_ctl_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] tick_period;
    logic [ACTIVE_W-1:0]   active_slots;
  } cfg_t;

endpackage

@@ sv/multi_slot_timeout_timer.sv @@
// Each transaction is taken from the input queue and its result pushed to the result queue;
// arm, disarm, unused codes and a tick sample that loads or repeats the reference go
// straight to the result. A tick sample with a changed value first runs the slot sweep,
// reading one slot count/limit per cycle from memory for n = min(active_slots, MAX_SLOTS).
// One transaction at a time: the next is taken only after the current result is pushed.
// Reset: synchronous, clears queues, running/expired flags and reference; tick_period
// goes to 65535, active_slots to 0; slot count/limit memories are not cleared.
module multi_slot_timeout_timer import mst_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [TICK_BITS-1:0]  tick_value,
  input  logic [SLOT_IDX_W-1:0] slot_index,
  input  logic [TICK_BITS-1:0]  setpoint,
  output logic                  empty,
  input  logic                  pop,
  output logic [TICK_BITS-1:0]  elapsed_ticks,
  output logic [FLAG_W-1:0]     expired_now,
  output logic [FLAG_W-1:0]     overflow_flags,
  output logic [FLAG_W-1:0]     running_flags
);

  localparam int RW = TICK_BITS + 3 * FLAG_W;

  cfg_t                 cfg;
  logic                 q_empty;
  logic                 q_pop;
  item_ctl_t            q_ctl;
  logic [TICK_BITS-1:0] q_tick;
  logic [TICK_BITS-1:0] q_setpoint;
  logic                 r_full;
  logic                 r_push;
  logic [TICK_BITS-1:0] r_elapsed;
  logic [FLAG_W-1:0]    r_expired_now;
  logic [FLAG_W-1:0]    r_overflow;
  logic [FLAG_W-1:0]    r_running;
  logic [RW-1:0]        r_wdata;
  logic [RW-1:0]        r_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_period  <= TICK_PERIOD_RST;
      cfg.active_slots <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TICK_PERIOD:  cfg.tick_period  <= cfg_data;
        REG_ACTIVE_SLOTS: cfg.active_slots <= cfg_data[ACTIVE_W-1:0];
      endcase
    end
  end

  mst_front #(
    .MAX_SLOTS (MAX_SLOTS),
    .TICK_BITS (TICK_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .tick_value (tick_value),
    .slot_index (slot_index),
    .setpoint   (setpoint),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_ctl      (q_ctl),
    .q_tick     (q_tick),
    .q_setpoint (q_setpoint)
  );

  mst_back #(
    .MAX_SLOTS (MAX_SLOTS),
    .TICK_BITS (TICK_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_ctl         (q_ctl),
    .q_tick        (q_tick),
    .q_setpoint    (q_setpoint),
    .r_full        (r_full),
    .r_push        (r_push),
    .r_elapsed     (r_elapsed),
    .r_expired_now (r_expired_now),
    .r_overflow    (r_overflow),
    .r_running     (r_running)
  );

  assign r_wdata = {r_elapsed, r_expired_now, r_overflow, r_running};

  mst_fifo #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .full  (r_full),
    .wdata (r_wdata),
    .empty (empty),
    .pop   (pop),
    .rdata (r_rdata)
  );

  assign {elapsed_ticks, expired_now, overflow_flags, running_flags} = r_rdata;

endmodule

@@ sv/mst_fifo.sv @@
module mst_fifo import mst_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  output logic             empty,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ sv/mst_front.sv @@
module mst_front import mst_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [TICK_BITS-1:0]  tick_value,
  input  logic [SLOT_IDX_W-1:0] slot_index,
  input  logic [TICK_BITS-1:0]  setpoint,
  output logic                  q_empty,
  input  logic                  q_pop,
  output item_ctl_t             q_ctl,
  output logic [TICK_BITS-1:0]  q_tick,
  output logic [TICK_BITS-1:0]  q_setpoint
);

  localparam int IW = $bits(item_ctl_t) + 2 * TICK_BITS;

  item_ctl_t     ctl;
  logic          slot_ok;
  logic [IW-1:0] wdata;
  logic [IW-1:0] rdata;

  assign slot_ok = (32'(slot_index) < MAX_SLOTS);

  // classify: out-of-range slots and unused codes become no-ops
  always_comb begin
    ctl.slot = slot_index;
    unique case (req_type)
      REQ_TICK:   ctl.op = OP_TICK;
      REQ_ARM:    ctl.op = slot_ok ? OP_ARM : OP_NOP;
      REQ_DISARM: ctl.op = slot_ok ? OP_DISARM : OP_NOP;
      default:    ctl.op = OP_NOP;
    endcase
  end

  assign wdata = {ctl, tick_value, setpoint};

  mst_fifo #(
    .WIDTH (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (wdata),
    .empty (q_empty),
    .pop   (q_pop),
    .rdata (rdata)
  );

  assign {q_ctl, q_tick, q_setpoint} = rdata;

endmodule

@@ sv/mst_back.sv @@
module mst_back import mst_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  item_ctl_t            q_ctl,
  input  logic [TICK_BITS-1:0] q_tick,
  input  logic [TICK_BITS-1:0] q_setpoint,
  input  logic                 r_full,
  output logic                 r_push,
  output logic [TICK_BITS-1:0] r_elapsed,
  output logic [FLAG_W-1:0]    r_expired_now,
  output logic [FLAG_W-1:0]    r_overflow,
  output logic [FLAG_W-1:0]    r_running
);

  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NW = $clog2(MAX_SLOTS + 1);
  localparam int PW = (TICK_BITS > CFG_DATA_W) ? TICK_BITS : CFG_DATA_W;

  back_state_t state, state_next;

  logic [TICK_BITS-1:0] ref_tick;
  logic                 ref_valid;
  logic [MAX_SLOTS-1:0] running;
  logic [MAX_SLOTS-1:0] expired;
  logic [TICK_BITS-1:0] elapsed;
  logic [FLAG_W-1:0]    now8;
  logic [NW-1:0]        rd_cnt;
  logic                 upd_vld;
  logic [SW-1:0]        upd_idx;

  logic [TICK_BITS-1:0] cnt_mem [MAX_SLOTS];
  logic [TICK_BITS-1:0] lim_mem [MAX_SLOTS];
  logic [TICK_BITS-1:0] cnt_rd;
  logic [TICK_BITS-1:0] lim_rd;

  logic                 start;
  logic                 go_sweep;
  logic                 issue;
  logic [7:0]           act_ext;
  logic [7:0]           n_ext;
  logic [NW-1:0]        n_act;
  logic [SW-1:0]        slot_a;
  logic [TICK_BITS-1:0] diff;
  logic [PW-1:0]        wrap;
  logic [TICK_BITS-1:0] elapsed_calc;
  logic [TICK_BITS:0]   sum;
  logic [TICK_BITS-1:0] sat;
  logic                 hit;
  logic                 upd_run;
  logic                 cnt_we;
  logic [SW-1:0]        cnt_wa;
  logic [TICK_BITS-1:0] cnt_wd;
  logic [FLAG_W-1:0]    run8;
  logic [FLAG_W-1:0]    exp8;

  assign act_ext = 8'(cfg.active_slots);
  assign n_ext   = (act_ext > 8'(MAX_SLOTS)) ? 8'(MAX_SLOTS) : act_ext;
  assign n_act   = NW'(n_ext);
  assign slot_a  = SW'(q_ctl.slot);

  assign diff = q_tick - ref_tick;
  assign wrap = PW'(PW'(cfg.tick_period) - PW'(ref_tick) + PW'(q_tick));
  assign elapsed_calc = (q_tick >= ref_tick) ? diff : wrap[TICK_BITS-1:0];

  assign go_sweep = (q_ctl.op == OP_TICK) && ref_valid && (q_tick != ref_tick);
  assign issue    = (state == ST_SWEEP) && (rd_cnt < n_act);

  assign sum     = {1'b0, cnt_rd} + {1'b0, elapsed};
  assign sat     = sum[TICK_BITS] ? '1 : sum[TICK_BITS-1:0];
  assign hit     = (sat >= lim_rd);
  assign upd_run = upd_vld && running[upd_idx];

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    r_push     = 1'b0;
    start      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          start      = 1'b1;
          state_next = go_sweep ? ST_SWEEP : ST_EMIT;
        end
      end
      ST_SWEEP: begin
        if (!issue && !upd_vld) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!r_full) begin
          r_push     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_valid <= 1'b0;
      running   <= '0;
      expired   <= '0;
      upd_vld   <= 1'b0;
    end else begin
      upd_vld <= issue;
      if (start) begin
        unique case (q_ctl.op)
          OP_TICK: begin
            ref_tick  <= q_tick;
            ref_valid <= 1'b1;
          end
          OP_ARM: begin
            running[slot_a] <= 1'b1;
            expired[slot_a] <= 1'b0;
          end
          OP_DISARM: begin
            running[slot_a] <= 1'b0;
            expired[slot_a] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (upd_run && hit) begin
        running[upd_idx] <= 1'b0;
        expired[upd_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      elapsed <= go_sweep ? elapsed_calc : '0;
      now8    <= '0;
      rd_cnt  <= '0;
    end else begin
      if (issue) begin
        rd_cnt  <= NW'(rd_cnt + 1'b1);
        upd_idx <= rd_cnt[SW-1:0];
      end
      if (upd_run && hit) begin
        now8 <= now8 | (FLAG_W'(1) << upd_idx);
      end
    end
  end

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = upd_idx;
    cnt_wd = hit ? '0 : sat;
    if (start && (q_ctl.op == OP_ARM)) begin
      cnt_we = 1'b1;
      cnt_wa = slot_a;
      cnt_wd = '0;
    end else if (upd_run) begin
      cnt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cnt_rd <= cnt_mem[rd_cnt[SW-1:0]];
      lim_rd <= lim_mem[rd_cnt[SW-1:0]];
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (start && (q_ctl.op == OP_ARM)) begin
      lim_mem[slot_a] <= q_setpoint;
    end
  end

  for (genvar g = 0; g < FLAG_W; g++) begin : g_flags
    if (g < MAX_SLOTS) begin : g_slot
      assign run8[g] = running[g];
      assign exp8[g] = expired[g];
    end else begin : g_none
      assign run8[g] = 1'b0;
      assign exp8[g] = 1'b0;
    end
  end

  assign r_elapsed     = elapsed;
  assign r_expired_now = now8;
  assign r_overflow    = exp8;
  assign r_running     = run8;

endmodule

@@ sv/mst_checker.sv @@
module mst_checker import mst_pkg::*; #(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  empty,
  input logic                  pop,
  input logic [TICK_BITS-1:0]  elapsed_ticks,
  input logic [FLAG_W-1:0]     expired_now,
  input logic [FLAG_W-1:0]     overflow_flags,
  input logic [FLAG_W-1:0]     running_flags
);

  // drain result queue on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a slot never counts and shows expired at once
  a_flags_disjoint: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((running_flags & overflow_flags) == '0))
    else $error("slot both running and expired");

  // an expiry of this transaction is sticky in the overflow flags
  a_now_in_overflow: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((expired_now & ~overflow_flags) == '0))
    else $error("expired_now bit without overflow flag");

  // hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(elapsed_ticks) && $stable(expired_now)
      && $stable(overflow_flags) && $stable(running_flags))
    else $error("stalled result changed");

endmodule

bind multi_slot_timeout_timer mst_checker #(.TICK_BITS(TICK_BITS)) u_mst_checker (.*);

@@ dv/multi_slot_timeout_timer_checker.sv @@
`timescale 1ns / 100ps

module multi_slot_timeout_timer_checker import mst_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     push,
  input  logic                     full,
  input  logic [REQ_W-1:0]         req_type,
  input  logic [TICK_BITS_DEF-1:0] tick_value,
  input  logic [SLOT_IDX_W-1:0]    slot_index,
  input  logic [TICK_BITS_DEF-1:0] setpoint,
  input  logic                     empty,
  input  logic                     pop,
  input  logic [TICK_BITS_DEF-1:0] elapsed_ticks,
  input  logic [FLAG_W-1:0]        expired_now,
  input  logic [FLAG_W-1:0]        overflow_flags,
  input  logic [FLAG_W-1:0]        running_flags,
  output int                       errors,
  output int                       pending
);

  typedef struct packed {
    logic [TICK_BITS_DEF-1:0] elapsed;
    logic [FLAG_W-1:0]        fired;
    logic [FLAG_W-1:0]        overflow;
    logic [FLAG_W-1:0]        running;
  } timer_status_t;

  timer_status_t            status_q[$];
  timer_status_t            want;
  logic [CFG_DATA_W-1:0]    period_reg;
  logic [ACTIVE_W-1:0]      active_reg;
  logic [TICK_BITS_DEF-1:0] ref_tick;
  logic                     ref_loaded;
  logic [FLAG_W-1:0]        run_mask;
  logic [FLAG_W-1:0]        ovf_mask;
  logic [TICK_BITS_DEF-1:0] slot_cnt [MAX_SLOTS_DEF];
  logic [TICK_BITS_DEF-1:0] slot_lim [MAX_SLOTS_DEF];

  function automatic timer_status_t apply_request(
    logic [REQ_W-1:0]         rq,
    logic [TICK_BITS_DEF-1:0] tick,
    logic [SLOT_IDX_W-1:0]    idx,
    logic [TICK_BITS_DEF-1:0] sp
  );
    timer_status_t            status;
    logic [TICK_BITS_DEF-1:0] gap;
    logic [TICK_BITS_DEF:0]   sum;
    int                       lanes;
    status = '0;
    case (rq)
      REQ_TICK: begin
        if (!ref_loaded) begin
          ref_tick   = tick;
          ref_loaded = 1'b1;
        end else if (tick != ref_tick) begin
          if (tick >= ref_tick) gap = tick - ref_tick;
          else gap = period_reg - ref_tick + tick;
          ref_tick = tick;
          lanes = (active_reg > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : active_reg;
          for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
            if (i < lanes && run_mask[i]) begin
              sum = {1'b0, slot_cnt[i]} + {1'b0, gap};
              if (sum[TICK_BITS_DEF]) sum = {1'b0, {TICK_BITS_DEF{1'b1}}};
              if (sum[TICK_BITS_DEF-1:0] >= slot_lim[i]) begin
                run_mask[i]     = 1'b0;
                ovf_mask[i]     = 1'b1;
                status.fired[i] = 1'b1;
                sum             = '0;
              end
              slot_cnt[i] = sum[TICK_BITS_DEF-1:0];
            end
          end
          status.elapsed = gap;
        end
      end
      REQ_ARM: begin
        slot_lim[idx] = sp;
        slot_cnt[idx] = '0;
        ovf_mask[idx] = 1'b0;
        run_mask[idx] = 1'b1;
      end
      REQ_DISARM: begin
        slot_lim[idx] = '0;
        slot_cnt[idx] = '0;
        ovf_mask[idx] = 1'b0;
        run_mask[idx] = 1'b0;
      end
      default: ;
    endcase
    status.overflow = ovf_mask;
    status.running  = run_mask;
    return status;
  endfunction

  task automatic compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      period_reg = TICK_PERIOD_RST;
      active_reg = '0;
      ref_tick   = '0;
      ref_loaded = 1'b0;
      run_mask   = '0;
      ovf_mask   = '0;
      for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
        slot_cnt[i] = '0;
        slot_lim[i] = '0;
      end
      status_q.delete();
      errors = 0;
    end else begin
      if (cfg_wen) begin
        if (cfg_index == REG_TICK_PERIOD) period_reg = cfg_data;
        else if (cfg_index == REG_ACTIVE_SLOTS) active_reg = cfg_data[ACTIVE_W-1:0];
      end
      if (push && !full)
        status_q.push_back(apply_request(req_type, tick_value, slot_index, setpoint));
      if (pop && !empty) begin
        if (status_q.size() == 0) begin
          $display("%0t: result with no transaction pending, actual %h %h %h %h", $time,
                   elapsed_ticks, expired_now, overflow_flags, running_flags);
          errors++;
        end else begin
          want = status_q.pop_front();
          compare_field("elapsed_ticks", want.elapsed, elapsed_ticks);
          compare_field("expired_now", 16'(want.fired), 16'(expired_now));
          compare_field("overflow_flags", 16'(want.overflow), 16'(overflow_flags));
          compare_field("running_flags", 16'(want.running), 16'(running_flags));
        end
      end
    end
    pending <= status_q.size();
  end

endmodule

@@ dv/multi_slot_timeout_timer_test.sv @@
`timescale 1ns / 100ps

module multi_slot_timeout_timer_test;
  import mst_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     push = 1'b0;
  logic                     full;
  logic [REQ_W-1:0]         req_type = '0;
  logic [TICK_BITS_DEF-1:0] tick_value = '0;
  logic [SLOT_IDX_W-1:0]    slot_index = '0;
  logic [TICK_BITS_DEF-1:0] setpoint = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [TICK_BITS_DEF-1:0] elapsed_ticks;
  logic [FLAG_W-1:0]        expired_now;
  logic [FLAG_W-1:0]        overflow_flags;
  logic [FLAG_W-1:0]        running_flags;
  int                       errors;
  int                       pending;

  logic        rx_hold = 1'b0;
  int          rx_idle = 0;
  int          tx_idle = 0;
  int          idle_cycles = 0;
  int unsigned clock_now = 0;
  int unsigned cur_period = 65535;

  multi_slot_timeout_timer uut (.*);

  multi_slot_timeout_timer_checker monitor (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || rx_hold) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("multi_slot_timeout_timer test failed");
      $finish;
    end
  end

  task automatic send_item(logic [REQ_W-1:0] rq, logic [15:0] tk, logic [2:0] ix,
                           logic [15:0] sp);
    while ($urandom_range(99) < tx_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    req_type   <= rq;
    tick_value <= tk;
    slot_index <= ix;
    setpoint   <= sp;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [15:0] period, logic [3:0] active);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_TICK_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    cfg_index <= REG_ACTIVE_SLOTS;
    cfg_data  <= {12'd0, active};
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    cur_period = 32'(period);
    clock_now  = clock_now % cur_period;
  endtask

  task automatic random_item();
    int               pick;
    logic [REQ_W-1:0] rq;
    logic [15:0]      tk;
    logic [15:0]      sp;
    logic [2:0]       ix;
    pick = $urandom_range(99);
    tk   = 16'($urandom);
    sp   = 16'($urandom);
    ix   = 3'($urandom);
    if (pick < 45) begin
      rq = REQ_TICK;
      if ($urandom_range(9) != 0) begin
        clock_now = (clock_now + $urandom_range(0, 150)) % cur_period;
        tk = 16'(clock_now);
      end else begin
        clock_now = 32'(tk);
      end
    end else if (pick < 75) begin
      rq = REQ_ARM;
      if ($urandom_range(3) != 0) sp = 16'($urandom_range(0, 400));
    end else if (pick < 90) begin
      rq = REQ_DISARM;
    end else begin
      rq = REQ_UNUSED;
    end
    send_item(rq, tk, ix, sp);
  endtask

  task automatic run_phase(logic [15:0] period, logic [3:0] active, int tx, int rx, int count);
    drain();
    write_config(period, active);
    tx_idle = tx;
    rx_idle <= rx;
    repeat (count) random_item();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: no active slots
    send_item(REQ_ARM, 16'd0, 3'd0, 16'd5);
    send_item(REQ_TICK, 16'd1000, 3'd0, 16'd0);
    send_item(REQ_TICK, 16'd2000, 3'd0, 16'd0);
    send_item(REQ_UNUSED, 16'hFFFF, 3'd7, 16'hFFFF);
    drain();
    write_config(16'hFFFF, 4'd8);
    send_item(REQ_ARM, 16'd0, 3'd1, 16'hFFFF);
    send_item(REQ_ARM, 16'd0, 3'd2, 16'd0);
    send_item(REQ_ARM, 16'd0, 3'd7, 16'd50);
    send_item(REQ_TICK, 16'd2000, 3'd0, 16'd0);
    send_item(REQ_TICK, 16'd2050, 3'd0, 16'd0);
    send_item(REQ_TICK, 16'd10, 3'd0, 16'd0);
    send_item(REQ_TICK, 16'hFFFF, 3'd0, 16'd0);
    send_item(REQ_ARM, 16'hFFFF, 3'd3, 16'hFFFF);
    send_item(REQ_TICK, 16'd0, 3'd0, 16'd0);
    send_item(REQ_DISARM, 16'd0, 3'd3, 16'd0);
    send_item(REQ_DISARM, 16'd0, 3'd7, 16'd0);
    send_item(REQ_DISARM, 16'd0, 3'd4, 16'd0);
    send_item(REQ_UNUSED, 16'd0, 3'd0, 16'd0);
    drain();
    // samples above the period, active count beyond the slot bank
    write_config(16'd100, 4'd15);
    send_item(REQ_ARM, 16'd0, 3'd0, 16'd30);
    send_item(REQ_TICK, 16'hFFF0, 3'd0, 16'd0);
    send_item(REQ_ARM, 16'd0, 3'd5, 16'd200);
    send_item(REQ_TICK, 16'd40, 3'd0, 16'd0);
    send_item(REQ_TICK, 16'd20, 3'd0, 16'd0);
    drain();
    write_config(16'd1000, 4'd3);
    send_item(REQ_ARM, 16'd0, 3'd6, 16'd1);
    send_item(REQ_TICK, 16'd500, 3'd0, 16'd0);
    send_item(REQ_TICK, 16'd900, 3'd0, 16'd0);

    run_phase(16'hFFFF, 4'd8, 0, 0, 300);
    run_phase(16'd1, 4'd15, 68, 0, 250);
    run_phase(16'd1000, 4'd3, 0, 68, 300);
    run_phase(16'd300, 4'd9, 14, 14, 300);

    // hold off the result side until the block backs up
    drain();
    write_config(16'hFFFF, 4'd8);
    tx_idle = 0;
    rx_idle <= 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
      repeat (40) random_item();
    join

    run_phase(16'd50000, 4'd0, 68, 68, 200);
    run_phase(16'd2000, 4'd8, 0, 0, 300);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("multi_slot_timeout_timer test passed");
    end else begin
      $display("multi_slot_timeout_timer test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/mst_pkg.sv
sv/mst_fifo.sv
sv/mst_front.sv
sv/mst_back.sv
sv/multi_slot_timeout_timer.sv
sv/mst_checker.sv
dv/multi_slot_timeout_timer_checker.sv
dv/multi_slot_timeout_timer_test.sv
